@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the smgd_back module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define SMGD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("smgd assertion failed");

// next-cycle implication, quiet during reset
`define SMGD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("smgd assertion failed");

`endif

@@ rtl/smgd_pkg.sv @@
// ----------------------------------------------------------------------------
// smgd_pkg
// Types, constants and bit helpers for the square marker grid decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package smgd_pkg;

    localparam int GRID_DIM   = 7;
    localparam int GRID_BITS  = GRID_DIM * GRID_DIM;
    localparam int INNER_DIM  = 5;
    localparam int INNER_BITS = INNER_DIM * INNER_DIM;
    localparam int NUM_ROT    = 4;
    localparam int NUM_WORDS  = 5;
    localparam int ID_BITS    = 10;
    localparam int DIST_BITS  = 5;
    localparam int ROW_DBITS  = 3;

    localparam logic [INNER_BITS-1:0] CW_RESET = 25'd29349759;

    typedef logic [GRID_BITS-1:0]  t_grid;
    typedef logic [INNER_BITS-1:0] t_matrix;
    typedef logic [ROW_DBITS-1:0]  t_row_dist;
    typedef logic [DIST_BITS-1:0]  t_dist;
    typedef logic [ID_BITS-1:0]    t_id;

    typedef struct packed {
        logic    border_ok;
        t_matrix matrix;
    } t_front_word;

    function automatic t_grid border_mask();
        t_grid m;
        m = '0;
        for (int r = 0; r < GRID_DIM; r++) begin
            for (int c = 0; c < GRID_DIM; c++) begin
                if (r == 0 || r == GRID_DIM-1 || c == 0 || c == GRID_DIM-1) begin
                    m[GRID_DIM*r + c] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    localparam t_grid BORDER_MASK = border_mask();

    // turned(i,j) = previous(4-j, i)
    function automatic t_matrix turn(input t_matrix m);
        t_matrix r;
        r = '0;
        for (int i = 0; i < INNER_DIM; i++) begin
            for (int j = 0; j < INNER_DIM; j++) begin
                r[INNER_DIM*i + j] = m[INNER_DIM*(INNER_DIM-1-j) + i];
            end
        end
        return r;
    endfunction

    function automatic t_row_dist pop5(input logic [INNER_DIM-1:0] v);
        t_row_dist n;
        n = '0;
        for (int k = 0; k < INNER_DIM; k++) begin
            n = n + {2'b00, v[k]};
        end
        return n;
    endfunction

    // columns 1 and 3 of each row, row 0 first, MSB first
    function automatic t_id matrix_id(input t_matrix m);
        t_id v;
        v = '0;
        for (int y = 0; y < INNER_DIM; y++) begin
            v[ID_BITS-1-2*y] = m[INNER_DIM*y + 1];
            v[ID_BITS-2-2*y] = m[INNER_DIM*y + 3];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/square_marker_grid_decoder_core.sv @@
// ----------------------------------------------------------------------------
// square_marker_grid_decoder_core
// Square fiducial marker decoder: border check, four rotations, row-code
// Hamming match against five configured words, id read-out.
//
//   channel   ports                                      handshake
//   -------   -----------------------------------------  ---------------------
//   cfg       i_cfg_valid o_cfg_ready i_cfg_data[24:0]   valid & ready
//   in        i_start o_busy i_cell_grid[48:0]           start & !busy
//   out       o_done o_border_ok o_found o_marker_id     one-cycle strobe
//             o_rotation o_best_distance
//
// One word per cycle sustained while busy is low. A taken grid passes the
// front register, the queue, the row-distance stage and the select stage
// before the result strobe rises.
// Reset is synchronous, active low; code words return to their reset value.
// The back end never stalls, so busy stays low in normal use; the queue
// absorbs front and back decoupling.
// ----------------------------------------------------------------------------
`default_nettype none

module square_marker_grid_decoder_core
    import smgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [24:0] i_cfg_data,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [48:0] i_cell_grid,
    output logic             o_done,
    output logic             o_border_ok,
    output logic             o_found,
    output logic [9:0]       o_marker_id,
    output logic [1:0]       o_rotation,
    output logic [4:0]       o_best_distance
);

    logic        f_push;
    t_front_word f_word;
    logic        q_ready;
    logic        q_valid;
    t_front_word q_word;
    logic        b_pop;

    assign o_cfg_ready = 1'b1;

    smgd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_cell_grid (i_cell_grid),
        .o_busy      (o_busy),
        .o_push      (f_push),
        .o_word      (f_word),
        .i_q_ready   (q_ready)
    );

    smgd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_word  (f_word),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_word  (q_word),
        .i_pop   (b_pop)
    );

    smgd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_word        (q_word),
        .o_pop           (b_pop),
        .o_done          (o_done),
        .o_border_ok     (o_border_ok),
        .o_found         (o_found),
        .o_marker_id     (o_marker_id),
        .o_rotation      (o_rotation),
        .o_best_distance (o_best_distance)
    );

endmodule

`default_nettype wire

@@ rtl/smgd_front.sv @@
// ----------------------------------------------------------------------------
// smgd_front
// Takes a cell grid, checks the border and pulls out the inner 5x5 matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module smgd_front
    import smgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_grid       i_cell_grid,
    output logic             o_busy,
    output logic             o_push,
    output t_front_word      o_word,
    input  wire logic        i_q_ready
);

    logic        r_valid;
    logic        n_valid;
    t_front_word r_word;
    t_front_word n_word;
    logic        accept;

    assign o_busy = r_valid && !i_q_ready;
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && i_q_ready;
    assign o_word = r_word;

    always_comb begin
        n_word.border_ok = ((i_cell_grid & BORDER_MASK) == '0);
        for (int y = 0; y < INNER_DIM; y++) begin
            for (int x = 0; x < INNER_DIM; x++) begin
                n_word.matrix[INNER_DIM*y + x] = i_cell_grid[GRID_DIM*(y+1) + (x+1)];
            end
        end
        n_valid = accept || (r_valid && !i_q_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smgd_queue.sv @@
// ----------------------------------------------------------------------------
// smgd_queue
// Two-entry queue of classified words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module smgd_queue
    import smgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_front_word i_word,
    output logic             o_ready,
    output logic             o_valid,
    output t_front_word      o_word,
    input  wire logic        i_pop
);

    t_front_word r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_count;
    logic        n_wptr;
    logic        n_rptr;
    logic [1:0]  n_count;
    logic        do_push;
    logic        do_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_word  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = do_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop  ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smgd_back.sv @@
// ----------------------------------------------------------------------------
// smgd_back
// Row distances for all four rotations, then sum, pick and report.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module smgd_back
    import smgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire t_matrix     i_cfg_data,
    input  wire logic        i_q_valid,
    input  wire t_front_word i_q_word,
    output logic             o_pop,
    output logic             o_done,
    output logic             o_border_ok,
    output logic             o_found,
    output t_id              o_marker_id,
    output logic [1:0]       o_rotation,
    output t_dist            o_best_distance
);

    t_matrix   r_code_words;
    t_matrix   rot      [NUM_ROT];
    t_row_dist n_dist   [NUM_ROT][INNER_DIM];

    logic      r_s1_valid;
    logic      r_s1_border;
    t_matrix   r_s1_rot  [NUM_ROT];
    t_row_dist r_s1_dist [NUM_ROT][INNER_DIM];

    t_dist     sum       [NUM_ROT];
    t_dist     best_d;
    logic [1:0] best_r;
    t_matrix   best_m;

    logic      r_done;
    logic      r_border_ok;
    logic      r_found;
    t_id       r_marker_id;
    logic [1:0] r_rotation;
    t_dist     r_best_distance;

    assign o_pop = i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_words <= CW_RESET;
        end else if (i_cfg_valid) begin
            r_code_words <= i_cfg_data;
        end
    end

    // stage 1: per-row minimum distance to the code words
    always_comb begin
        t_row_dist d;
        t_row_dist b;
        rot[0] = i_q_word.matrix;
        for (int r = 1; r < NUM_ROT; r++) begin
            rot[r] = turn(rot[r-1]);
        end
        for (int r = 0; r < NUM_ROT; r++) begin
            for (int y = 0; y < INNER_DIM; y++) begin
                b = 3'd5;
                for (int p = 0; p < NUM_WORDS; p++) begin
                    d = pop5(rot[r][INNER_DIM*y +: INNER_DIM]
                             ^ r_code_words[INNER_DIM*p +: INNER_DIM]);
                    if (d < b) begin
                        b = d;
                    end
                end
                n_dist[r][y] = b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_valid) begin
            r_s1_border <= i_q_word.border_ok;
            r_s1_rot    <= rot;
            r_s1_dist   <= n_dist;
        end
    end

    // stage 2: sum rows, lowest sum wins, ties to the lower rotation
    always_comb begin
        for (int r = 0; r < NUM_ROT; r++) begin
            sum[r] = '0;
            for (int y = 0; y < INNER_DIM; y++) begin
                sum[r] = sum[r] + {2'b00, r_s1_dist[r][y]};
            end
        end
        best_d = sum[0];
        best_r = 2'd0;
        best_m = r_s1_rot[0];
        for (int r = 1; r < NUM_ROT; r++) begin
            if (sum[r] < best_d) begin
                best_d = sum[r];
                best_r = 2'(r);
                best_m = r_s1_rot[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_border_ok     <= r_s1_border;
            r_found         <= r_s1_border && (best_d == '0);
            r_marker_id     <= (r_s1_border && (best_d == '0)) ? matrix_id(best_m) : '0;
            r_rotation      <= r_s1_border ? best_r : 2'd0;
            r_best_distance <= r_s1_border ? best_d : '0;
        end
    end

    assign o_done          = r_done;
    assign o_border_ok     = r_border_ok;
    assign o_found         = r_found;
    assign o_marker_id     = r_marker_id;
    assign o_rotation      = r_rotation;
    assign o_best_distance = r_best_distance;

    `SMGD_ASSERT_NEXT(a_pop_reaches_out, i_q_valid, r_s1_valid ##1 r_done)
    `SMGD_ASSERT_NOW(a_found_zero_dist, r_done && r_found, r_border_ok && (r_best_distance == '0))
    `SMGD_ASSERT_NOW(a_border_fail_clear, r_done && !r_border_ok, (r_rotation == 2'd0) && (r_marker_id == '0) && (r_best_distance == '0))
    `SMGD_ASSERT_NOW(a_not_found_no_id, r_done && !r_found, r_marker_id == '0)

endmodule

`default_nettype wire
